[src/mrc_pkg.sv]
package mrc_pkg;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 8;
  localparam int CRC_W      = 16;
  localparam int MIN_LENGTH = 4;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
  localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h01;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_ADDRESS = 2'd2,
    ST_CRC     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_START = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  // classified word handed from the front to the back
  typedef struct packed {
    kind_t             kind;
    logic              hash;
    logic [BYTE_W-1:0] data;
    logic              last;
    status_t           pre_status;
    logic [POS_W-1:0]  start;
  } word_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                               input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/mrc_in_if.sv]
interface mrc_in_if
  import mrc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

[src/mrc_out_if.sv]
interface mrc_out_if
  import mrc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       check_status;
  logic [POS_W-1:0] frame_start;

  modport source (output valid, output check_status, output frame_start, input ready);
  modport sink   (input valid, input check_status, input frame_start, output ready);
endinterface

[src/mrc_front.sv]
module mrc_front
  import mrc_pkg::*;
#(
  parameter int BURST_CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  mrc_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              q_push,
  output word_t             q_word
);

  localparam int CNT_W = $clog2(BURST_CAPACITY + 1);

  logic [BYTE_W-1:0] addr_r;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              seen_r, seen_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [CNT_W-1:0]  since_r, since_nxt;
  logic              take;
  word_t             word;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;
  assign take        = total_r < CNT_W'(BURST_CAPACITY);

  always_comb begin
    total_nxt       = total_r;
    seen_nxt        = seen_r;
    start_nxt       = start_r;
    since_nxt       = since_r;
    word.kind       = KIND_SKIP;
    word.hash       = 1'b0;
    word.data       = in_ch.rx_byte;
    word.last       = in_ch.frame_end;
    word.pre_status = ST_OK;
    word.start      = start_r;
    if (take) begin
      total_nxt = total_r + CNT_W'(1);
      if (seen_r) begin
        word.kind = KIND_DATA;
        word.hash = since_r >= CNT_W'(2);
        since_nxt = since_r + CNT_W'(1);
      end else if (in_ch.rx_byte == addr_r) begin
        word.kind = KIND_START;
        seen_nxt  = 1'b1;
        start_nxt = POS_W'(total_r);
        since_nxt = CNT_W'(1);
      end
    end
    word.start = start_nxt;
    if (total_nxt <= CNT_W'(MIN_LENGTH)) begin
      word.pre_status = ST_SHORT;
    end else if (!seen_nxt || since_nxt <= CNT_W'(MIN_LENGTH)) begin
      word.pre_status = ST_ADDRESS;
    end
    // frame state returns to reset once the burst ends
    if (in_ch.frame_end) begin
      total_nxt = '0;
      seen_nxt  = 1'b0;
      start_nxt = '0;
      since_nxt = '0;
    end
  end

  assign q_word = word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= ADDR_RESET;
      total_r <= '0;
      seen_r  <= 1'b0;
      start_r <= '0;
      since_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        addr_r <= cfg_wr_data;
      end
      if (q_push) begin
        total_r <= total_nxt;
        seen_r  <= seen_nxt;
        start_r <= start_nxt;
        since_r <= since_nxt;
      end
    end
  end

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(BURST_CAPACITY))
    else $error("byte count above capacity");

  a_seen_since: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (since_r != '0 && since_r <= total_r))
    else $error("frame length inconsistent with address state");

endmodule

[src/mrc_queue.sv]
module mrc_queue
  import mrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  word_t push_word,
  output logic  full,
  input  logic  pop,
  output word_t pop_word,
  output logic  empty
);

  word_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full     = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_word = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= Q_CNT_W'(Q_DEPTH)) && (Q_PTR_W'(wr_ptr_r - rd_ptr_r) == Q_PTR_W'(cnt_r)))
    else $error("queue pointers disagree with count");

endmodule

[src/mrc_back.sv]
module mrc_back
  import mrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  word_t    q_word,
  output logic     q_pop,
  mrc_out_if.source out_ch
);

  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] tail0_r, tail0_nxt;
  logic [BYTE_W-1:0] tail1_r, tail1_nxt;
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;

  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    crc_nxt   = crc_r;
    tail0_nxt = tail0_r;
    tail1_nxt = tail1_r;
    case (q_word.kind)
      KIND_START: begin
        tail0_nxt = '0;
        tail1_nxt = q_word.data;
      end
      KIND_DATA: begin
        if (q_word.hash) begin
          crc_nxt = crc_byte(crc_r, tail0_r);
        end
        tail0_nxt = tail1_r;
        tail1_nxt = q_word.data;
      end
      default: begin
      end
    endcase
    status_nxt = q_word.pre_status;
    start_nxt  = '0;
    if (q_word.pre_status == ST_OK) begin
      if ({tail1_nxt, tail0_nxt} != crc_nxt) begin
        status_nxt = ST_CRC;
      end else begin
        start_nxt = q_word.start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      tail0_r     <= '0;
      tail1_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && q_word.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_word.last) begin
          crc_r   <= CRC_INIT;
          tail0_r <= '0;
          tail1_r <= '0;
        end else begin
          crc_r   <= crc_nxt;
          tail0_r <= tail0_nxt;
          tail1_r <= tail1_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_word.last) begin
      status_r <= status_nxt;
      start_r  <= start_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.check_status = status_r;
  assign out_ch.frame_start  = start_r;

  a_start_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |-> (start_r == '0))
    else $error("frame start reported on a failed frame");

  a_crc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_word.last) |=> (crc_r == CRC_INIT && out_valid_r))
    else $error("burst end did not restart crc and post a result");

endmodule

[src/modbus_rtu_reply_frame_checker.sv]
// result: the last byte is written to a queue entry, then popped into the result register,
// which holds the result word once the queue has no earlier words and the register is free
// throughput: one byte per cycle while the queue has room; a four-word queue parts byte intake
// from crc update, whose one byte per cycle while out_ch takes results sets the sustained rate
// reset: synchronous active-low rst_n clears frame state, crc to ffff, address to 01
module modbus_rtu_reply_frame_checker
  import mrc_pkg::*;
#(
  parameter int BURST_CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  mrc_in_if.sink            in_ch,
  mrc_out_if.source         out_ch
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  word_t push_word;
  word_t pop_word;

  mrc_front #(
    .BURST_CAPACITY(BURST_CAPACITY)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_word      (push_word)
  );

  mrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .empty     (q_empty)
  );

  mrc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_word  (pop_word),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mrc_pkg::*;

  localparam int BURST_CAPACITY = 256;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_NS     = 2_000_000;

  typedef struct {
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;
  } rx_word_t;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] start;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [BYTE_W-1:0] cfg_wr_data = '0;

  mrc_in_if  in_if ();
  mrc_out_if out_if ();

  modbus_rtu_reply_frame_checker #(
    .BURST_CAPACITY(BURST_CAPACITY)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

  rx_word_t          pending_words[$];
  reply_t            expected_replies[$];
  logic [BYTE_W-1:0] burst_buf[$];
  rx_word_t          next_word;
  int                items_queued = 0;
  int                error_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              hold_armed = 1'b0;
  logic              hold_off = 1'b0;

  // frame checker state as seen by the predictor
  logic [BYTE_W-1:0] station_addr = ADDR_RESET;
  logic [8:0]        seen_total;
  logic              addr_found;
  logic [POS_W-1:0]  start_idx;
  logic [8:0]        since_start;
  logic [CRC_W-1:0]  crc_acc;
  logic [BYTE_W-1:0] tail_old;
  logic [BYTE_W-1:0] tail_new;

  initial begin
    in_if.valid     = 1'b0;
    in_if.rx_byte   = '0;
    in_if.frame_end = 1'b0;
    out_if.ready    = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [CRC_W-1:0] crc16_shift(input logic [CRC_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic clear_reply_model();
    seen_total  = '0;
    addr_found  = 1'b0;
    start_idx   = '0;
    since_start = '0;
    crc_acc     = CRC_INIT;
    tail_old    = '0;
    tail_new    = '0;
  endtask

  task automatic advance_reply_model(input logic [BYTE_W-1:0] b, input logic last);
    reply_t r;
    if (seen_total < BURST_CAPACITY) begin
      if (addr_found) begin
        if (since_start >= 2) crc_acc = crc16_shift(crc_acc, tail_old);
        tail_old = tail_new;
        tail_new = b;
        if (since_start < 9'h1FF) since_start++;
      end else if (b == station_addr) begin
        addr_found  = 1'b1;
        start_idx   = seen_total[POS_W-1:0];
        since_start = 9'd1;
        tail_old    = '0;
        tail_new    = b;
      end
      seen_total++;
    end
    if (last) begin
      r.start = '0;
      if (seen_total <= MIN_LENGTH) begin
        r.status = ST_SHORT;
      end else if (!addr_found || since_start <= MIN_LENGTH) begin
        r.status = ST_ADDRESS;
      end else if ({tail_new, tail_old} != crc_acc) begin
        r.status = ST_CRC;
      end else begin
        r.status = ST_OK;
        r.start  = start_idx;
      end
      expected_replies.push_back(r);
      clear_reply_model();
    end
  endtask

  task automatic check_reply(input logic [1:0] got_status, input logic [POS_W-1:0] got_start);
    reply_t r;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("reply status %0d start %0d with none expected",
                                got_status, got_start));
    end else begin
      r = expected_replies.pop_front();
      if (got_status !== r.status)
        report_mismatch($sformatf("check_status got %0d exp %0d", got_status, r.status));
      if (got_start !== r.start)
        report_mismatch($sformatf("frame_start got %0d exp %0d", got_start, r.start));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      clear_reply_model();
    end else begin
      if (in_if.valid && in_if.ready) advance_reply_model(in_if.rx_byte, in_if.frame_end);
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          in_if.valid     <= 1'b1;
          in_if.rx_byte   <= next_word.rx_byte;
          in_if.frame_end <= next_word.frame_end;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_reply(out_if.check_status, out_if.frame_start);
      out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold so the block backs up and stalls its input
  initial begin
    wait (hold_armed);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic logic [BYTE_W-1:0] noise_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(255)); while (b == station_addr);
    return b;
  endfunction

  task automatic add_noise(input int n);
    repeat (n) burst_buf.push_back(noise_byte());
  endtask

  task automatic append_crc(input int from_idx);
    logic [CRC_W-1:0] c;
    c = CRC_INIT;
    for (int i = from_idx; i < burst_buf.size(); i++) c = crc16_shift(c, burst_buf[i]);
    burst_buf.push_back(c[7:0]);
    burst_buf.push_back(c[15:8]);
  endtask

  task automatic add_frame(input int n_payload);
    int fs;
    fs = burst_buf.size();
    burst_buf.push_back(station_addr);
    repeat (n_payload)
      burst_buf.push_back(($urandom_range(7) == 0) ? station_addr : 8'($urandom_range(255)));
    append_crc(fs);
  endtask

  task automatic flush_burst();
    rx_word_t w;
    foreach (burst_buf[i]) begin
      w.rx_byte   = burst_buf[i];
      w.frame_end = (i == burst_buf.size() - 1);
      pending_words.push_back(w);
    end
    items_queued += burst_buf.size();
    burst_buf.delete();
  endtask

  task automatic add_random_burst();
    int kind;
    int fs;
    int pos;
    kind = $urandom_range(99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 10)) burst_buf.push_back(8'($urandom_range(255)));
    end else begin
      add_noise(($urandom_range(7) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3));
      fs = burst_buf.size();
      add_frame(($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12));
      if (kind >= 65 && kind < 80) begin
        pos = $urandom_range(fs + 1, burst_buf.size() - 1);
        burst_buf[pos] = burst_buf[pos] ^ (8'h01 << $urandom_range(7));
      end else if (kind >= 80) begin
        repeat ($urandom_range(1, 2)) void'(burst_buf.pop_back());
      end
    end
    flush_burst();
  endtask

  task automatic add_random_phase(input int n_items);
    int base;
    base = items_queued;
    while (items_queued - base < n_items) add_random_burst();
  endtask

  task automatic wait_quiet();
    while (pending_words.size() != 0 || in_if.valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_station_addr(input logic [BYTE_W-1:0] v);
    @(posedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= v;
    station_addr = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n          <= 1'b1;
    send_idle_pct  <= 7;
    recv_stall_pct <= 65;
    @(posedge clk);

    // directed bursts with the reset address
    burst_buf = '{8'h00, 8'hFF};
    flush_burst();
    burst_buf = '{8'h01};
    flush_burst();
    burst_buf = '{8'h02, 8'h80, 8'h7F, 8'h00, 8'hFE};
    flush_burst();
    burst_buf = '{8'h55, 8'h01, 8'h01, 8'h03, 8'h04};
    flush_burst();
    burst_buf = '{8'h01, 8'h03, 8'h00};
    append_crc(0);
    flush_burst();
    burst_buf = '{8'h01, 8'h03, 8'h00};
    append_crc(0);
    burst_buf[3] = burst_buf[3] ^ 8'h80;
    flush_burst();

    wait_quiet();
    write_station_addr(8'h00);
    // frame ending exactly at capacity, then ignored bytes
    add_noise(247);
    add_frame(6);
    repeat (5) burst_buf.push_back(8'($urandom_range(255)));
    flush_burst();
    add_random_phase(100);

    wait_quiet();
    send_idle_pct  <= 65;
    recv_stall_pct <= 7;
    write_station_addr(8'hFF);
    add_random_phase(150);

    wait_quiet();
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    write_station_addr(8'($urandom_range(1, 254)));
    hold_armed = 1'b1;
    add_random_phase(150);

    wait_quiet();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
